### hw/rtl/acls_pkg.sv
// Shared types and constants for the ANSI colour line splitter.
package acls_pkg;

  // Byte codes the parser looks for
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SEQ_END = 8'h6D;  // 'm'
  localparam logic [7:0] CH_BRACKET = 8'h5B;  // '['
  localparam logic [7:0] CH_SEMI    = 8'h3B;  // ';'
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  localparam logic [2:0] PREFIX_LEN = 3'd5;
  localparam int         MAX_BEATS  = 3;

  // Top-level parse mode
  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_SEQ  = 2'd2
  } mode_t;

  // Progress through one numeric parameter
  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // Results of one input byte, as handed from front to back
  typedef struct packed {
    logic [1:0]                     cnt;    // number of beats, 1 to 3
    logic [MAX_BEATS-1:0]           done;   // per beat: end-of-line item
    logic [MAX_BEATS-1:0][7:0]      txt;    // per beat: text byte
    logic [23:0]                    color;  // colour for the end item
  } rec_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic nonempty;
  } qstat_t;

  // Characters of the truecolour prefix "38;2;"
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h33;
      3'd1:    c = 8'h38;
      3'd2:    c = CH_SEMI;
      3'd3:    c = 8'h32;
      3'd4:    c = CH_SEMI;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/acls_front.sv
// Front end: parses each byte, updates line state and builds a result record.
module acls_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                in_ready,
  input  acls_pkg::qstat_t    qstat,
  output logic                push,
  output acls_pkg::rec_t      push_rec
);
  import acls_pkg::*;

  mode_t       mode, mode_next;
  logic [2:0]  pcount, pcount_next;
  logic        pok, pok_next;
  logic [1:0]  nidx, nidx_next;
  phase_t      phase, phase_next;
  logic        neg, neg_next;
  logic [7:0]  acc, acc_next;
  logic [7:0]  red, red_next;
  logic [7:0]  green, green_next;
  logic        failed, failed_next;
  logic [23:0] color, color_next;
  logic        nonempty, nonempty_next;
  rec_t        rec;
  logic        accept;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  // Append one beat to a record
  function automatic rec_t add_beat(input rec_t r, input logic [7:0] t,
                                    input logic d);
    rec_t o;
    o = r;
    o.txt[r.cnt]  = t;
    o.done[r.cnt] = d;
    o.cnt         = r.cnt + 2'd1;
    return o;
  endfunction

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (rec.cnt != 2'd0);
  assign push_rec = rec;

  // Per-byte parse and record build
  always_comb begin
    logic        skip;
    logic        digit;
    logic [7:0]  d;
    logic [7:0]  sv;
    logic [7:0]  blue;
    logic        ok;
    mode_next     = mode;
    pcount_next   = pcount;
    pok_next      = pok;
    nidx_next     = nidx;
    phase_next    = phase;
    neg_next      = neg;
    acc_next      = acc;
    red_next      = red;
    green_next    = green;
    failed_next   = failed;
    color_next    = color;
    nonempty_next = nonempty;
    rec           = '0;
    skip          = 1'b0;
    digit         = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    d             = in_byte - CH_ZERO;
    sv            = neg ? (8'd0 - acc) : acc;
    blue          = 8'd0;
    ok            = 1'b0;

    if (in_byte == CH_NL) begin
      if (mode == MODE_ESC) rec = add_beat(rec, CH_ESC, 1'b0);
      if (nonempty) rec = add_beat(rec, 8'd0, 1'b1);
      rec.color     = color;
      mode_next     = MODE_TEXT;
      color_next    = 24'd0;
      nonempty_next = 1'b0;
      pcount_next = '0; pok_next = 1'b1; nidx_next = '0; phase_next = PH_WAIT;
      neg_next = 1'b0; acc_next = '0; red_next = '0; green_next = '0;
      failed_next = 1'b0;
    end else begin
      nonempty_next = 1'b1;
      // pending ESC resolves on this byte
      if (mode == MODE_ESC) begin
        if (in_byte == CH_BRACKET) begin
          mode_next = MODE_SEQ;
          skip      = 1'b1;
          pcount_next = '0; pok_next = 1'b1; nidx_next = '0; phase_next = PH_WAIT;
          neg_next = 1'b0; acc_next = '0; red_next = '0; green_next = '0;
          failed_next = 1'b0;
        end else begin
          rec       = add_beat(rec, CH_ESC, 1'b0);
          mode_next = MODE_TEXT;
        end
      end
      if (!skip) begin
        if (mode_next == MODE_SEQ) begin
          if (in_byte == CH_SEQ_END) begin
            // close sequence: take the colour if the scan completed
            if (pok && !failed && (pcount == PREFIX_LEN)) begin
              if (phase == PH_DONE) begin
                blue = acc;
                ok   = 1'b1;
              end else if ((phase == PH_DIGITS) && (nidx >= 2'd2)) begin
                blue = sv;
                ok   = 1'b1;
              end
              if (ok) color_next = {red, green, blue};
            end
            mode_next = MODE_TEXT;
            pcount_next = '0; pok_next = 1'b1; nidx_next = '0; phase_next = PH_WAIT;
            neg_next = 1'b0; acc_next = '0; red_next = '0; green_next = '0;
            failed_next = 1'b0;
          end else if (pok && !failed) begin
            if (pcount < PREFIX_LEN) begin
              if (in_byte == prefix_char(pcount)) pcount_next = pcount + 3'd1;
              else pok_next = 1'b0;
            end else begin
              case (phase)
                PH_WAIT: begin
                  if (digit) begin
                    acc_next   = d;
                    phase_next = PH_DIGITS;
                  end else if ((in_byte == CH_PLUS) || (in_byte == CH_MINUS)) begin
                    neg_next   = (in_byte == CH_MINUS);
                    phase_next = PH_SIGN;
                  end else if (!is_blank(in_byte)) begin
                    failed_next = 1'b1;
                  end
                end
                PH_SIGN: begin
                  if (digit) begin
                    acc_next   = d;
                    phase_next = PH_DIGITS;
                  end else begin
                    failed_next = 1'b1;
                  end
                end
                PH_DIGITS: begin
                  if (digit) begin
                    acc_next = 8'((acc * 8'd10) + d);
                  end else if (nidx >= 2'd2) begin
                    acc_next   = sv;
                    neg_next   = 1'b0;
                    phase_next = PH_DONE;
                  end else if (in_byte == CH_SEMI) begin
                    if (nidx == 2'd0) red_next = sv;
                    else green_next = sv;
                    nidx_next  = nidx + 2'd1;
                    phase_next = PH_WAIT;
                    neg_next   = 1'b0;
                    acc_next   = 8'd0;
                  end else begin
                    failed_next = 1'b1;
                  end
                end
                default: ;
              endcase
            end
          end
        end else if (in_byte == CH_ESC) begin
          mode_next = MODE_ESC;
        end else begin
          mode_next = MODE_TEXT;
          rec       = add_beat(rec, in_byte, 1'b0);
        end
      end
      // end of chunk closes the line
      if (in_last) begin
        if (mode_next == MODE_ESC) rec = add_beat(rec, CH_ESC, 1'b0);
        rec           = add_beat(rec, 8'd0, 1'b1);
        rec.color     = color_next;
        mode_next     = MODE_TEXT;
        color_next    = 24'd0;
        nonempty_next = 1'b0;
        pcount_next = '0; pok_next = 1'b1; nidx_next = '0; phase_next = PH_WAIT;
        neg_next = 1'b0; acc_next = '0; red_next = '0; green_next = '0;
        failed_next = 1'b0;
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_TEXT;
      pcount   <= '0;
      pok      <= 1'b1;
      nidx     <= '0;
      phase    <= PH_WAIT;
      neg      <= 1'b0;
      acc      <= '0;
      red      <= '0;
      green    <= '0;
      failed   <= 1'b0;
      color    <= '0;
      nonempty <= 1'b0;
    end else if (accept) begin
      mode     <= mode_next;
      pcount   <= pcount_next;
      pok      <= pok_next;
      nidx     <= nidx_next;
      phase    <= phase_next;
      neg      <= neg_next;
      acc      <= acc_next;
      red      <= red_next;
      green    <= green_next;
      failed   <= failed_next;
      color    <= color_next;
      nonempty <= nonempty_next;
    end
  end

endmodule

### hw/rtl/acls_queue.sv
// Small record queue between parser front end and output back end.
module acls_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  acls_pkg::rec_t    push_rec,
  input  logic              pop,
  output acls_pkg::rec_t    head_rec,
  output acls_pkg::qstat_t  qstat
);
  import acls_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          store [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign do_push        = push && (count != CW'(DEPTH));
  assign do_pop         = pop && (count != '0);
  assign head_rec       = store[rptr];
  assign qstat.full     = (count == CW'(DEPTH));
  assign qstat.nonempty = (count != '0);

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) store[wptr] <= push_rec;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      if (do_pop)  rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/acls_back.sv
// Back end: unrolls each record into output beats, one per cycle while out_ready is high.
module acls_back (
  input  logic              clk,
  input  logic              rst,
  input  acls_pkg::rec_t    head_rec,
  input  acls_pkg::qstat_t  qstat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_text,
  output logic              out_done,
  output logic [23:0]       out_color,
  output logic              out_last
);
  import acls_pkg::*;

  rec_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       load;

  assign out_valid = cur_valid;
  assign out_text  = cur.txt[idx];
  assign out_done  = cur.done[idx];
  assign out_color = cur.done[idx] ? cur.color : 24'd0;
  assign out_last  = (idx == (cur.cnt - 2'd1));
  assign load      = !cur_valid || (out_ready && out_last);
  assign pop       = load && qstat.nonempty;

  // Current record payload
  always_ff @(posedge clk) begin
    if (pop) cur <= head_rec;
  end

  // Beat sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= qstat.nonempty;
      idx       <= '0;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

### hw/rtl/ansi_color_line_splitter_core.sv
// Top level of the ANSI colour line splitter: front parser, queue, back end.
//
//  channel   dir  fields (low bit first)
//  s_axis    in   tdata: data_byte[7:0]; tlast: chunk_end
//  m_axis    out  tdata: text_byte[7:0], line_color[31:8]; tuser: line_done;
//                 tlast: last result of an input byte
//
// One input byte is accepted every cycle while the queue has room. Each byte
// yields zero to three output beats, sent one per cycle while the output is
// ready; bytes with no result never enter the queue. A record is queued, then
// loaded into the back end, before it is sent. A stalled output fills the
// QUEUE_DEPTH-entry queue, then holds s_axis_tready low. Synchronous reset
// returns the parser to text mode with black colour and empties the queue.
module ansi_color_line_splitter_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] text_byte, [31:8] line_color
  output logic        m_axis_tuser,   // [0] line_done
  output logic        m_axis_tlast
);
  import acls_pkg::*;

  qstat_t      qstat;
  rec_t        push_rec, head_rec;
  logic        push, pop;
  logic [7:0]  out_text;
  logic [23:0] out_color;

  acls_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .qstat    (qstat),
    .push     (push),
    .push_rec (push_rec)
  );

  acls_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .qstat    (qstat)
  );

  acls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_rec  (head_rec),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_text  (out_text),
    .out_done  (m_axis_tuser),
    .out_color (out_color),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_color, out_text};

  // An end-of-line item always closes the results of its byte
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("end item not marked last");

  // Text items carry no colour
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[31:8] == 24'd0))
    else $error("text item with colour");

  // Front never pushes into a full queue
  assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("push into full queue");

  // Nothing is offered right after reset
  assert property (@(posedge clk) (!rst && $past(rst)) |-> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

### dv/line_split_monitor.sv
// Monitor for the colour line splitter: predicts output beats from accepted input bytes.
module line_split_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        run_done,
  output int          fails,
  output int          backlog
);
  timeunit 1ns;
  timeprecision 1ps;
  import acls_pkg::*;

  localparam int PRINT_LIMIT = 30;
  // "38;2;" with the first character in the low byte
  localparam logic [4:0][7:0] TRUECOLOR_PREFIX = {CH_SEMI, 8'h32, CH_SEMI, 8'h38, 8'h33};

  typedef struct packed {
    logic [7:0]  text;
    logic        done;
    logic [23:0] colour;
    logic        last;
  } line_beat_t;

  // Predicted parser state
  mode_t       parse_state;
  logic [2:0]  pfx_cnt;
  logic        pfx_ok;
  logic [1:0]  num_idx;
  phase_t      num_phase;
  logic        neg;
  logic [7:0]  acc;
  logic [7:0]  red;
  logic [7:0]  green;
  logic        scan_bad;
  logic [23:0] line_colour;
  logic        line_open;

  line_beat_t  beats_due[$];
  line_beat_t  byte_beats[MAX_BEATS];
  int          byte_beat_cnt;
  int          mismatch_count = 0;
  bit          leftovers_seen = 0;

  assign fails = mismatch_count;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic void clear_scan();
    pfx_cnt   = '0;
    pfx_ok    = 1'b1;
    num_idx   = '0;
    num_phase = PH_WAIT;
    neg       = 1'b0;
    acc       = '0;
    red       = '0;
    green     = '0;
    scan_bad  = 1'b0;
  endfunction

  function automatic void clear_line();
    parse_state = MODE_TEXT;
    clear_scan();
    line_colour = '0;
    line_open   = 1'b0;
  endfunction

  // Number with its sign applied, two's complement in 8 bits
  function automatic logic [7:0] signed_acc();
    return neg ? (8'd0 - acc) : acc;
  endfunction

  function automatic void add_beat(input logic [7:0] t, input logic d, input logic [23:0] c);
    if (byte_beat_cnt < MAX_BEATS) begin
      byte_beats[byte_beat_cnt] = '{text: t, done: d, colour: c, last: 1'b0};
      byte_beat_cnt++;
    end
  endfunction

  // One byte of the parameter string, scanf %d style
  function automatic void scan_param(input logic [7:0] b);
    logic digit;
    logic is_blank;
    digit    = (b >= CH_ZERO) && (b <= CH_NINE);
    is_blank = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    if (!pfx_ok || scan_bad) return;
    if (pfx_cnt < PREFIX_LEN) begin
      if (b == TRUECOLOR_PREFIX[pfx_cnt]) pfx_cnt++;
      else pfx_ok = 1'b0;
      return;
    end
    case (num_phase)
      PH_WAIT: begin
        if (digit) begin
          acc       = b - CH_ZERO;
          num_phase = PH_DIGITS;
        end else if (b == CH_PLUS || b == CH_MINUS) begin
          neg       = (b == CH_MINUS);
          num_phase = PH_SIGN;
        end else if (!is_blank) begin
          scan_bad = 1'b1;
        end
      end
      PH_SIGN: begin
        if (digit) begin
          acc       = b - CH_ZERO;
          num_phase = PH_DIGITS;
        end else begin
          scan_bad = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (digit) begin
          acc = acc * 8'd10 + (b - CH_ZERO);
        end else if (num_idx >= 2'd2) begin
          // third number finished; rest of the parameters ignored
          acc       = signed_acc();
          neg       = 1'b0;
          num_phase = PH_DONE;
        end else if (b == CH_SEMI) begin
          if (num_idx == 2'd0) red = signed_acc();
          else green = signed_acc();
          num_idx++;
          num_phase = PH_WAIT;
          neg       = 1'b0;
          acc       = '0;
        end else begin
          scan_bad = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // Closing 'm': commit the colour if all three numbers parsed
  function automatic void close_sequence();
    if (pfx_ok && !scan_bad && pfx_cnt == PREFIX_LEN) begin
      if (num_phase == PH_DONE) line_colour = {red, green, acc};
      else if (num_phase == PH_DIGITS && num_idx >= 2'd2)
        line_colour = {red, green, signed_acc()};
    end
    clear_scan();
  endfunction

  task automatic split_and_strip(input logic [7:0] b, input logic ce);
    logic taken;
    taken         = 1'b0;
    byte_beat_cnt = 0;
    if (b == CH_NL) begin
      if (parse_state == MODE_ESC) add_beat(CH_ESC, 1'b0, '0);
      if (line_open) add_beat(8'h00, 1'b1, line_colour);
      clear_line();
    end else begin
      line_open = 1'b1;
      if (parse_state == MODE_ESC) begin
        if (b == CH_BRACKET) begin
          parse_state = MODE_SEQ;
          clear_scan();
          taken = 1'b1;
        end else begin
          // lone ESC goes out as text
          add_beat(CH_ESC, 1'b0, '0);
          parse_state = MODE_TEXT;
        end
      end
      if (!taken) begin
        if (parse_state == MODE_SEQ) begin
          if (b == CH_SEQ_END) begin
            close_sequence();
            parse_state = MODE_TEXT;
          end else begin
            scan_param(b);
          end
        end else if (b == CH_ESC) begin
          parse_state = MODE_ESC;
        end else begin
          parse_state = MODE_TEXT;
          add_beat(b, 1'b0, '0);
        end
      end
      if (ce) begin
        if (parse_state == MODE_ESC) add_beat(CH_ESC, 1'b0, '0);
        add_beat(8'h00, 1'b1, line_colour);
        clear_line();
      end
    end
    if (byte_beat_cnt > 0) byte_beats[byte_beat_cnt-1].last = 1'b1;
    for (int i = 0; i < byte_beat_cnt; i++) beats_due = {beats_due, byte_beats[i]};
  endtask

  task automatic check_beat();
    line_beat_t want;
    if (beats_due.size() == 0) begin
      report_mismatch($sformatf("result with nothing due: tdata=%08h tuser=%0b tlast=%0b",
                                m_axis_tdata, m_axis_tuser, m_axis_tlast));
      return;
    end
    want = beats_due.pop_front();
    if (m_axis_tdata[7:0] != want.text)
      report_mismatch($sformatf("text_byte %02h, expected %02h", m_axis_tdata[7:0], want.text));
    if (m_axis_tuser != want.done)
      report_mismatch($sformatf("line_done %0b, expected %0b", m_axis_tuser, want.done));
    if (m_axis_tdata[31:8] != want.colour)
      report_mismatch($sformatf("line_color %06h, expected %06h",
                                m_axis_tdata[31:8], want.colour));
    if (m_axis_tlast != want.last)
      report_mismatch($sformatf("last %0b, expected %0b", m_axis_tlast, want.last));
  endtask

  // Sample both channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      beats_due.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) split_and_strip(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_beat();
      if (run_done && !leftovers_seen) begin
        leftovers_seen = 1;
        if (beats_due.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", beats_due.size()));
      end
    end
    backlog <= beats_due.size();
  end

endmodule

### dv/ansi_color_line_splitter_core_test.sv
// Top of the colour line splitter testbench: clock, reset, stimulus and verdict.
module ansi_color_line_splitter_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import acls_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 10;
  localparam int PHASE_ITEMS    = 56;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        run_done = 1'b0;

  int          fails;
  int          backlog;
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 0;
  bit          hold_served = 0;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  logic [7:0]  line_buf[$];

  ansi_color_line_splitter_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  line_split_monitor line_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .run_done      (run_done),
    .fails         (fails),
    .backlog       (backlog)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off to back the block up
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served = 1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic ce);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= ce;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_line(input bit ce_last);
    foreach (line_buf[i]) send_byte(line_buf[i], ce_last && (i == line_buf.size() - 1));
    line_buf.delete();
  endtask

  // Append one byte to the line being built
  function automatic void put_char(input logic [7:0] c);
    line_buf = {line_buf, c};
  endfunction

  function automatic void push_chars(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  // Optional blanks, optional sign, 0 to 4 digits
  function automatic void push_number();
    int blanks;
    int sign_pick;
    int digits;
    blanks    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    sign_pick = $urandom_range(0, 9);
    digits    = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
    repeat (blanks) begin
      case ($urandom_range(0, 3))
        0:       put_char(CH_SPACE);
        1:       put_char(CH_TAB);
        2:       put_char(CH_CR);
        default: put_char(8'h0B);
      endcase
    end
    if (sign_pick == 0) put_char(CH_PLUS);
    else if (sign_pick == 1) put_char(CH_MINUS);
    repeat (digits) put_char(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  // ESC [ 38;2;R;G;B m with occasional corruption or no closing byte
  function automatic void push_colour_seq();
    int first;
    put_char(CH_ESC);
    put_char(CH_BRACKET);
    first = line_buf.size();
    push_chars("38;2;");
    if ($urandom_range(0, 9) == 0)
      line_buf[first + $urandom_range(0, 4)] = 8'($urandom_range(32, 126));
    push_number();
    put_char(CH_SEMI);
    if ($urandom_range(0, 19) == 0) put_char(8'($urandom_range(32, 126)));
    push_number();
    put_char(CH_SEMI);
    push_number();
    if ($urandom_range(0, 4) == 0) begin
      put_char(8'($urandom_range(32, 126)));
      put_char(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 9) != 0) put_char(CH_SEQ_END);
  endfunction

  function automatic void push_text();
    logic [7:0] c;
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 6) != 0) begin
        c = 8'($urandom_range(32, 126));
      end else begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_NL);
      end
      put_char(c);
    end
  endfunction

  // A line of text, colour sequences and stray ESCs, ended by newline or chunk end
  task automatic send_random_line();
    int pick;
    repeat ($urandom_range(0, 4)) begin
      pick = $urandom_range(0, 9);
      if (pick < 4 || pick == 9) push_text();
      else if (pick < 8) push_colour_seq();
      else put_char(CH_ESC);
    end
    if (line_buf.size() != 0 && $urandom_range(0, 4) == 0) begin
      send_line(1'b1);
    end else begin
      put_char(CH_NL);
      send_line($urandom_range(0, 9) == 0);
    end
  endtask

  // Sender stops until every predicted result has come out
  task automatic pause_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall);
    int goal;
    idle_pct  = idle;
    stall_pct = stall;
    goal      = bytes_sent + PHASE_ITEMS;
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 9) == 0)
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 31) == 0);
      else
        send_random_line();
    end
    pause_for_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty line with chunk end on the newline
    send_byte(CH_NL, 1'b1);
    // byte extremes, line closed by chunk end
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // ESC not followed by '[', then ESC as last byte before newline
    send_byte(CH_ESC, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(CH_ESC, 1'b0);
    send_byte(CH_NL, 1'b0);
    // ESC as the final byte of a chunk
    send_byte(CH_ESC, 1'b1);
    // negative and oversized numbers, chunk end on the closing byte
    put_char(CH_ESC);
    push_chars("[38;2;-1;300;7m");
    send_line(1'b1);
    // unclosed sequence
    put_char(CH_ESC);
    push_chars("[1");
    send_line(1'b1);
    pause_for_results();

    // Random: first phase also holds the receiver off for a long stretch
    hold_req = 1;
    run_phase(0, 0);
    run_phase(88, 0);
    run_phase(0, 88);
    run_phase(11, 11);

    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fails == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
